### rtl/core/trial_division_prime_test_macros.svh
// Assertion macros for the trial division prime test block.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TDPT_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TDPT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/tdpt_pkg.sv
// Package for the trial division prime test block: widths, constants,
// controller state type and the command/status structs. No dependencies.
package tdpt_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int TWIN_GAP    = 2;
    localparam int FIRST_DIV   = 2;
    localparam int FIRST_SQ    = FIRST_DIV * FIRST_DIV;

    localparam int DIV_BITS   = 8;
    localparam int DIV_CHUNKS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int SH_W       = DIV_CHUNKS * DIV_BITS;
    localparam int D_W        = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W       = 2 * D_W;
    localparam int CNT_W      = $clog2(DIV_CHUNKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_value;
        logic load_twin;
        logic div_step;
        logic div_next;
        logic set_result;
        logic res_prime;
        logic res_twin;
    } t_dp_cmd;

    typedef struct packed {
        logic n_small;
        logic sq_over;
        logic next_over;
        logic div_last;
        logic rem_zero;
        logic twin_fits;
    } t_dp_sts;

endpackage

### rtl/core/trial_division_prime_test.sv
// Top level of the trial division prime test block.
// Instantiates tdpt_ctrl and tdpt_dp; uses tdpt_pkg.
//
// channel   signals                           transfer
// command   start, busy, i_value              start high and busy low at a rising edge
// result    o_done, o_is_prime, o_twin_start  o_done high for one cycle
//
// busy covers the trial divisions for the value and, when value plus 2 is also tested,
// for that candidate too; a new value is accepted only after busy falls. Each divisor
// passes through the shared remainder unit, 8 dividend bits per cycle.
// Synchronous active-low reset returns the controller to idle.
// busy stays high from acceptance through the result cycle.
// The result strobe cannot be stalled.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic                   o_done,
    output logic                   o_is_prime,
    output logic                   o_twin_start
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    tdpt_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_done  (o_done)
    );

    tdpt_dp u_dp (
        .i_clk        (i_clk),
        .i_value      (i_value),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_is_prime   (o_is_prime),
        .o_twin_start (o_twin_start)
    );

endmodule

### rtl/core/tdpt_dp.sv
// Datapath: candidate and divisor registers, running square bound and a
// shared remainder unit that retires DIV_BITS dividend bits per cycle. Uses tdpt_pkg.
module tdpt_dp
    import tdpt_pkg::*;
(
    input  logic                   i_clk,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts,
    output logic                   o_is_prime,
    output logic                   o_twin_start
);

    logic [VALUE_WIDTH-1:0] r_v;
    logic [VALUE_WIDTH-1:0] r_n;
    logic [D_W-1:0]         r_d;
    logic [SQ_W-1:0]        r_sq;
    logic [SH_W-1:0]        r_sh;
    logic [D_W-1:0]         r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_is_prime;
    logic                   r_twin_start;

    logic [D_W-1:0]         n_rem;
    logic [SH_W-1:0]        n_sh;
    logic [SQ_W-1:0]        n_sq;
    logic [D_W:0]           w_trial;
    logic [VALUE_WIDTH:0]   w_twin;

    always_comb begin
        n_rem   = r_rem;
        n_sh    = r_sh;
        w_trial = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            w_trial = {n_rem, n_sh[SH_W-1]};
            if (w_trial >= {1'b0, r_d}) begin
                n_rem = D_W'(w_trial - {1'b0, r_d});
            end else begin
                n_rem = w_trial[D_W-1:0];
            end
            n_sh = {n_sh[SH_W-2:0], 1'b0};
        end
    end

    assign n_sq   = r_sq + SQ_W'({r_d, 1'b0}) + SQ_W'(1);
    assign w_twin = {1'b0, r_v} + (VALUE_WIDTH+1)'(TWIN_GAP);

    assign o_sts.n_small   = (r_n < VALUE_WIDTH'(FIRST_DIV));
    assign o_sts.sq_over   = (r_sq > SQ_W'(r_n));
    assign o_sts.next_over = (n_sq > SQ_W'(r_n));
    assign o_sts.div_last  = (r_cnt == CNT_W'(DIV_CHUNKS - 1));
    assign o_sts.rem_zero  = (n_rem == '0);
    assign o_sts.twin_fits = !w_twin[VALUE_WIDTH];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_value) begin
            r_v   <= i_value;
            r_n   <= i_value;
            r_d   <= D_W'(FIRST_DIV);
            r_sq  <= SQ_W'(FIRST_SQ);
            r_sh  <= SH_W'(i_value);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load_twin) begin
            r_n   <= w_twin[VALUE_WIDTH-1:0];
            r_d   <= D_W'(FIRST_DIV);
            r_sq  <= SQ_W'(FIRST_SQ);
            r_sh  <= SH_W'(w_twin[VALUE_WIDTH-1:0]);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_next) begin
            r_d   <= r_d + D_W'(1);
            r_sq  <= n_sq;
            r_sh  <= SH_W'(r_n);
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_sh  <= n_sh;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.set_result) begin
            r_is_prime   <= i_cmd.res_prime;
            r_twin_start <= i_cmd.res_twin;
        end
    end

    assign o_is_prime   = r_is_prime;
    assign o_twin_start = r_twin_start;

endmodule

### rtl/core/tdpt_ctrl.sv
// Controller: sequences the value test, the optional value-plus-two test and
// the result strobe. Uses tdpt_pkg and the assertion macro header.
`include "trial_division_prime_test_macros.svh"

module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_done
);

    t_state r_state;
    t_state n_state;
    logic   r_phase;
    logic   n_phase;
    logic   fin;
    logic   fin_prime;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    // test verdict for the current candidate
    always_comb begin
        fin       = 1'b0;
        fin_prime = 1'b0;
        case (r_state)
            S_CHECK: begin
                if (i_sts.n_small) begin
                    fin = 1'b1;
                end else if (i_sts.sq_over) begin
                    fin       = 1'b1;
                    fin_prime = 1'b1;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    if (i_sts.rem_zero) begin
                        fin = 1'b1;
                    end else if (i_sts.next_over) begin
                        fin       = 1'b1;
                        fin_prime = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.load_value = start;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_next = i_sts.div_last && !fin;
            end
            default: ;
        endcase
        if (fin) begin
            if (!r_phase && fin_prime && i_sts.twin_fits) begin
                o_cmd.load_twin = 1'b1;
            end else begin
                o_cmd.set_result = 1'b1;
                o_cmd.res_prime  = r_phase | fin_prime;
                o_cmd.res_twin   = r_phase & fin_prime;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                    n_phase = 1'b0;
                end
            end
            S_CHECK: begin
                if (!fin) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: ;
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            if (!r_phase && fin_prime && i_sts.twin_fits) begin
                n_state = S_CHECK;
                n_phase = 1'b1;
            end else begin
                n_state = S_DONE;
            end
        end
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    `TDPT_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, o_done, !o_done, "done held")
    `TDPT_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_done, !busy, "busy after done")
    `TDPT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept ignored")
    `TDPT_ASSERT_NEXT(a_result_done, i_clk, i_rst_n, o_cmd.set_result, o_done, "no strobe")
    `TDPT_ASSERT_SAME(a_twin_prime, i_clk, i_rst_n, o_cmd.set_result && o_cmd.res_twin,
        o_cmd.res_prime, "twin without prime")

endmodule

### bench/trial_division_prime_test_tb.sv
// Testbench for trial_division_prime_test: drives values on the command port and
// checks is_prime / twin_start against an in-bench trial-division predictor.
// Depends on tdpt_pkg and the trial_division_prime_test RTL only.
`timescale 1ns / 100ps

module trial_division_prime_test_tb;
    import tdpt_pkg::*;

    localparam int          CLK_PERIOD  = 10;
    localparam int          RESET_HOLD  = 10;
    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          DRAIN_WAIT  = 40;
    localparam int unsigned VALUE_MAX   = (1 << VALUE_WIDTH) - 1;

    typedef struct packed {
        logic is_prime;
        logic twin_start;
    } t_flags;

    class prime_scoreboard;
        t_flags pending_flags[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit is_prime_value(int unsigned n);
            int unsigned d;
            if (n < FIRST_DIV) begin
                return 1'b0;
            end
            for (d = FIRST_DIV; d * d <= n; d++) begin
                if (n % d == 0) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_value(logic [VALUE_WIDTH-1:0] value);
            t_flags      flags;
            int unsigned v;
            v                = value;
            flags.is_prime   = is_prime_value(v);
            flags.twin_start = flags.is_prime && (v + TWIN_GAP <= VALUE_MAX)
                               && is_prime_value(v + TWIN_GAP);
            pending_flags.push_back(flags);
        endfunction

        function void report_mismatch(string msg);
            mismatches++;
            $display("MISMATCH at %0t: %s", $time, msg);
        endfunction

        function void check_result(logic is_prime, logic twin_start);
            t_flags want;
            if (pending_flags.size() == 0) begin
                report_mismatch($sformatf("result with no item pending (prime=%b twin=%b)",
                                          is_prime, twin_start));
                return;
            end
            want = pending_flags.pop_front();
            if (is_prime !== want.is_prime) begin
                report_mismatch($sformatf("is_prime %b, expected %b", is_prime,
                                          want.is_prime));
            end
            if (twin_start !== want.twin_start) begin
                report_mismatch($sformatf("twin_start %b, expected %b", twin_start,
                                          want.twin_start));
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VALUE_WIDTH-1:0] i_value;
    logic                   o_done;
    logic                   o_is_prime;
    logic                   o_twin_start;

    prime_scoreboard sb;
    int unsigned     cycle_count;
    int              idle_pct;

    trial_division_prime_test dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_is_prime  (o_is_prime),
        .o_twin_start(o_twin_start)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("trial_division_prime_test verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                sb.check_result(o_is_prime, o_twin_start);
            end
            if (start && !busy) begin
                sb.note_value(i_value);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start   <= 1'b0;
            i_value <= VALUE_WIDTH'($urandom);
            @(negedge i_clk);
            while ($urandom_range(99) < idle_pct) begin
                @(negedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (busy) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    function automatic int unsigned next_prime(int unsigned from);
        int unsigned v;
        v = from;
        while (!sb.is_prime_value(v)) begin
            v = (v >= VALUE_MAX) ? 0 : v + 1;
        end
        return v;
    endfunction

    function automatic int unsigned next_twin(int unsigned from);
        int unsigned v;
        v = from;
        while (!(v + TWIN_GAP <= VALUE_MAX && sb.is_prime_value(v)
                 && sb.is_prime_value(v + TWIN_GAP))) begin
            v = (v >= VALUE_MAX) ? 0 : v + 1;
        end
        return v;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2: begin
                return VALUE_WIDTH'($urandom);
            end
            3, 4, 5: begin
                return VALUE_WIDTH'(next_prime($urandom_range(VALUE_MAX)));
            end
            6, 7: begin
                return VALUE_WIDTH'(next_twin($urandom_range(VALUE_MAX)));
            end
            8: begin
                return VALUE_WIDTH'($urandom_range(64));
            end
            default: begin
                return VALUE_WIDTH'($urandom_range(VALUE_MAX, VALUE_MAX - 40));
            end
        endcase
    endfunction

    task automatic run_random(input int count, input int pct);
        idle_pct = pct;
        repeat (count) begin
            send_value(pick_value());
        end
    endtask

    logic [VALUE_WIDTH-1:0] directed_values[$] = '{
        16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd11, 16'd17, 16'd25,
        16'd49, 16'd169, 16'd4091, 16'd32749, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA,
        16'd65519, 16'd65521, 16'd65531, 16'd65533, 16'd65534, 16'hFFFF
    };

    initial begin
        sb          = new();
        cycle_count = 0;
        idle_pct    = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;
        repeat (RESET_HOLD) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_values[k]) begin
            send_value(directed_values[k]);
        end

        run_random(200, 0);
        run_random(180, 88);
        run_random(200, 25);

        start <= 1'b0;
        while (sb.pending_flags.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("trial_division_prime_test verification clean");
        end else begin
            $display("trial_division_prime_test verification failed");
        end
        $finish;
    end

endmodule

### trial_division_prime_test.f
+incdir+rtl/core
rtl/core/tdpt_pkg.sv
rtl/core/tdpt_dp.sv
rtl/core/tdpt_ctrl.sv
rtl/core/trial_division_prime_test.sv
bench/trial_division_prime_test_tb.sv
